FILE: rtl/core/afhc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, fixed-point constants and payload types for the frame hold controller.
// No dependencies.

package afhc_pkg;

  localparam int DRAIN_W   = 24;  // drain amount and hold cap
  localparam int GRAD_W    = 18;  // signed Q16 gradient, covers +-1.0
  localparam int MAG_W     = 17;  // |0.5 - average| in Q16
  localparam int FRAC_BITS = 16;  // fractional quotient bits of the gradient
  localparam int EW_W      = 34;  // EWMA accumulator, signed

  localparam int JITTER_DIV = 50;  // jitter is one fiftieth of a frame
  localparam int DIV_REM_W  = 6;   // remainder of a divide by JITTER_DIV

  localparam int EWMA_ALPHA = 1311;   // 0.02 in Q16
  localparam int EWMA_KEEP  = 64225;  // 1.0 - alpha in Q16

  typedef logic [DRAIN_W-1:0]        drain_t;
  typedef logic signed [GRAD_W-1:0]  grad_t;
  typedef logic [MAG_W-1:0]          mag_t;

  localparam drain_t HOLD_CAP_RESET = 24'd60000;
  localparam grad_t  Q_HALF         = 18'sd32768;
  localparam grad_t  Q_ONE          = 18'sd65536;

endpackage

FILE: rtl/core/afhc_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: frame events in, hold results out, hold cap writes.
// Depends on afhc_pkg.

interface afhc_frame_if #(parameter int TIME_WIDTH = 48);
  logic                  valid;
  logic                  ready;
  logic                  enable;
  logic [TIME_WIDTH-1:0] arrive_time;

  modport source (output valid, enable, arrive_time, input ready);
  modport sink   (input valid, enable, arrive_time, output ready);
endinterface

interface afhc_hold_if
  import afhc_pkg::*;
#(parameter int TIME_WIDTH = 48);
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] hold_ticks;
  drain_t                drain_ticks;
  grad_t                 gradient_average;
  logic                  gradient_updated;

  modport source (output valid, hold_ticks, drain_ticks, gradient_average, gradient_updated,
                  input ready);
  modport sink   (input valid, hold_ticks, drain_ticks, gradient_average, gradient_updated,
                  output ready);
endinterface

interface afhc_cfg_if
  import afhc_pkg::*;
;
  logic   valid;
  logic   ready;
  drain_t hold_cap_ticks;

  modport source (output valid, hold_cap_ticks, input ready);
  modport sink   (input valid, hold_cap_ticks, output ready);
endinterface

FILE: rtl/core/adaptive_frame_hold_controller.sv
`timescale 1ns / 1ps
// Adaptive frame hold controller: jitter/drain hold with a Q16 EWMA of the frame-time gradient.
// Depends on afhc_pkg, afhc_ifs (channel interfaces) and afhc_div50.
//
//   channel    dir  beat carries
//   frame_in   in   enable, arrive_time
//   hold_out   out  hold_ticks, drain_ticks, gradient_average, gradient_updated
//   cfg        in   hold_cap_ticks (always ready)
//
// One frame event at a time; the result sits in an output register so the next
// beat is taken while it waits. Disabled, first and non-positive-time events go
// straight from evaluation to the output register. A jitter frame waits on the
// serial divide by 50. A gradient frame runs 16 fractional quotient steps plus
// 17 shift-add multiplier steps (only the multiplier steps when the gradient saturates).
// Reset is synchronous; a stalled hold_out holds the block in its last step until
// the beat is taken.

module adaptive_frame_hold_controller
  import afhc_pkg::*;
#(
  parameter int TIME_WIDTH = 48
) (
  input  logic         clk,
  input  logic         rst,
  afhc_frame_if.sink   frame_in,
  afhc_hold_if.source  hold_out,
  afhc_cfg_if.sink     cfg
);

  localparam int TW   = TIME_WIDTH;
  localparam int FC_W = $clog2(FRAC_BITS);
  localparam int MC_W = $clog2(MAG_W);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVAL  = 4'd1;
  localparam logic [3:0] S_CLAMP = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_JIT   = 4'd4;
  localparam logic [3:0] S_GSAT  = 4'd5;
  localparam logic [3:0] S_FRAC  = 4'd6;
  localparam logic [3:0] S_EW1   = 4'd7;
  localparam logic [3:0] S_EW2   = 4'd8;
  localparam logic [3:0] S_MINIT = 4'd9;
  localparam logic [3:0] S_MUL   = 4'd10;
  localparam logic [3:0] S_DRAIN = 4'd11;
  localparam logic [3:0] S_REL   = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  logic [3:0]    state;

  // controller state
  logic          started;
  logic [TW-1:0] last_release;
  logic [TW-1:0] prev_ft;
  logic [TW-1:0] prev_jit;
  grad_t         smooth;
  drain_t        drain;
  drain_t        cap;

  // per-event working registers
  logic          en_r;
  logic [TW-1:0] now_r;
  logic [TW-1:0] ft_r;
  drain_t        max_drain;
  logic [TW-1:0] dmag;
  logic          gneg;
  logic [TW-1:0] hold_r;
  logic          upd_r;
  logic [TW:0]   frem;
  logic [FRAC_BITS-1:0] fq;
  logic [FC_W-1:0] fcnt;
  grad_t         g_r;
  logic signed [EW_W-1:0] ew_acc;
  mag_t          m_r;
  logic          mneg;
  logic [TW:0]   macc;
  logic [MC_W-1:0] mcnt;

  // output register
  logic          out_valid;
  logic [TW-1:0] out_hold;
  drain_t        out_drain;
  grad_t         out_grad;
  logic          out_upd;

  // divider
  logic          div_start;
  logic          div_done;
  logic [TW-1:0] div_q;

  // combinational helpers
  logic [TW-1:0] ft_now;
  logic [TW-1:0] half_ft;
  drain_t        maxd_c;
  drain_t        drain_clamped;
  logic [TW:0]   ft_up;
  logic [TW:0]   ft_dn;
  logic [TW:0]   f_sh;
  logic          f_sub_ok;
  logic [FRAC_BITS-1:0] frac_mag;
  grad_t         g_ext;
  logic signed [EW_W-1:0] ew_sum;
  logic signed [GRAD_W:0] mdiff;
  logic signed [GRAD_W:0] mabs;
  logic [TW+1:0] mul_sum;
  drain_t        room;

  afhc_div50 #(.TIME_WIDTH(TW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ft_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    ft_now  = now_r - last_release;
    half_ft = ft_r >> 1;
    if (half_ft >= TW'(cap)) begin
      maxd_c = cap;
    end else begin
      maxd_c = half_ft[DRAIN_W-1:0];
    end
    drain_clamped = (drain > maxd_c) ? maxd_c : drain;

    // both directions in parallel; borrow of the upward one picks
    ft_up = {1'b0, ft_r} - {1'b0, prev_ft};
    ft_dn = {1'b0, prev_ft} - {1'b0, ft_r};

    f_sh     = {frem[TW-1:0], 1'b0};
    f_sub_ok = (f_sh >= {1'b0, prev_jit});
    frac_mag = {fq[FRAC_BITS-2:0], f_sub_ok};
    g_ext    = GRAD_W'(frac_mag);

    ew_sum = ew_acc + EW_W'(smooth) * EW_W'(EWMA_KEEP) + EW_W'(Q_HALF);

    mdiff = (GRAD_W+1)'(Q_HALF) - (GRAD_W+1)'(smooth);
    mabs  = mdiff[GRAD_W] ? -mdiff : mdiff;

    // right-shift accumulate keeps floor(m * prev_jit / 2^17) exact
    mul_sum = {1'b0, macc} + (m_r[0] ? (TW+2)'(prev_jit) : '0);

    room = max_drain - drain;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      started      <= 1'b0;
      last_release <= '0;
      prev_ft      <= '0;
      prev_jit     <= '0;
      smooth       <= Q_HALF;
      drain        <= '0;
      cap          <= HOLD_CAP_RESET;
      out_valid    <= 1'b0;
      div_start    <= 1'b0;
      fcnt         <= '0;
      mcnt         <= '0;
    end else begin
      if (cfg.valid) begin
        cap <= cfg.hold_cap_ticks;
      end
      // S_EMIT reloads the output register itself
      if (out_valid && hold_out.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (frame_in.valid) begin
            en_r  <= frame_in.enable;
            now_r <= frame_in.arrive_time;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          hold_r <= '0;
          upd_r  <= 1'b0;
          if (!en_r) begin
            started      <= 1'b0;
            last_release <= '0;
            prev_ft      <= '0;
            prev_jit     <= '0;
            smooth       <= Q_HALF;
            drain        <= '0;
            state        <= S_EMIT;
          end else if (!started) begin
            started      <= 1'b1;
            last_release <= now_r;
            state        <= S_EMIT;
          end else if (ft_now == '0 || ft_now[TW-1]) begin
            last_release <= now_r;
            state        <= S_EMIT;
          end else begin
            ft_r  <= ft_now;
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          max_drain <= maxd_c;
          drain     <= drain_clamped;
          hold_r    <= TW'(drain_clamped);
          gneg      <= !ft_up[TW];
          dmag      <= ft_up[TW] ? ft_dn[TW-1:0] : ft_up[TW-1:0];
          if (prev_jit == '0) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end else begin
            state <= S_GSAT;
          end
        end
        S_DIV: begin
          div_start <= 1'b0;
          if (div_done) begin
            state <= S_JIT;
          end
        end
        S_JIT: begin
          hold_r   <= div_q + TW'(drain);
          prev_ft  <= ft_r;
          prev_jit <= div_q;
          upd_r    <= 1'b0;
          state    <= S_REL;
        end
        S_GSAT: begin
          if (dmag >= prev_jit) begin
            g_r   <= gneg ? -Q_ONE : Q_ONE;
            state <= S_EW1;
          end else begin
            frem  <= {1'b0, dmag};
            fq    <= '0;
            fcnt  <= '0;
            state <= S_FRAC;
          end
        end
        S_FRAC: begin
          frem <= f_sub_ok ? (f_sh - {1'b0, prev_jit}) : f_sh;
          fq   <= frac_mag;
          fcnt <= fcnt + 1'b1;
          if (fcnt == FC_W'(FRAC_BITS-1)) begin
            g_r   <= gneg ? -g_ext : g_ext;
            state <= S_EW1;
          end
        end
        S_EW1: begin
          ew_acc <= EW_W'(g_r) * EW_W'(EWMA_ALPHA);
          state  <= S_EW2;
        end
        S_EW2: begin
          smooth <= GRAD_W'(ew_sum >>> 16);
          state  <= S_MINIT;
        end
        S_MINIT: begin
          mneg  <= mdiff[GRAD_W];
          m_r   <= mabs[MAG_W-1:0];
          macc  <= '0;
          mcnt  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          macc <= mul_sum[TW+1:1];
          m_r  <= m_r >> 1;
          mcnt <= mcnt + 1'b1;
          if (mcnt == MC_W'(MAG_W-1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!mneg) begin
            drain <= (macc >= (TW+1)'(room)) ? max_drain : drain + macc[DRAIN_W-1:0];
          end else begin
            drain <= (macc >= (TW+1)'(drain)) ? '0 : drain - macc[DRAIN_W-1:0];
          end
          prev_ft  <= ft_r;
          prev_jit <= '0;
          upd_r    <= 1'b1;
          state    <= S_REL;
        end
        S_REL: begin
          last_release <= now_r + hold_r;
          state        <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || hold_out.ready) begin
            out_hold  <= hold_r;
            out_drain <= drain;
            out_grad  <= smooth;
            out_upd   <= upd_r;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign frame_in.ready            = (state == S_IDLE);
  assign cfg.ready                 = 1'b1;
  assign hold_out.valid            = out_valid;
  assign hold_out.hold_ticks       = out_hold;
  assign hold_out.drain_ticks      = out_drain;
  assign hold_out.gradient_average = out_grad;
  assign hold_out.gradient_updated = out_upd;

endmodule

FILE: rtl/core/afhc_div50.sv
`timescale 1ns / 1ps
// Bit-serial divide by JITTER_DIV: one quotient bit per cycle, MSB first.
// Depends on afhc_pkg.

module afhc_div50
  import afhc_pkg::*;
#(
  parameter int TIME_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [TIME_WIDTH-1:0] dividend,
  output logic                  done,
  output logic [TIME_WIDTH-1:0] quotient
);

  localparam int CNT_W = $clog2(TIME_WIDTH);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIV_REM_W-1:0]  rem;
  logic [DIV_REM_W-1:0]  rem_next;
  logic [TIME_WIDTH-1:0] shreg;
  logic [DIV_REM_W:0]    trial;
  logic                  qbit;

  // dividend bits leave at the top while quotient bits enter at the bottom
  always_comb begin
    trial = {rem, shreg[TIME_WIDTH-1]};
    if (trial >= (DIV_REM_W+1)'(JITTER_DIV)) begin
      qbit     = 1'b1;
      rem_next = DIV_REM_W'(trial - (DIV_REM_W+1)'(JITTER_DIV));
    end else begin
      qbit     = 1'b0;
      rem_next = trial[DIV_REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(TIME_WIDTH-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[TIME_WIDTH-2:0], qbit};
    end
  end

  assign quotient = shreg;

endmodule

FILE: rtl/core/afhc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the frame hold controller, bound to the top level.
// Depends on afhc_pkg and adaptive_frame_hold_controller.

module afhc_checker
  import afhc_pkg::*;
#(
  parameter int TIME_WIDTH = 48
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [TIME_WIDTH-1:0] hold_ticks,
  input grad_t                 gradient_average,
  input logic                  gradient_updated
);

  // one event in flight: the input side closes right after a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an event was in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hold_ticks))
    else $error("stalled result dropped or changed");

  a_grad_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gradient_average >= -Q_ONE) && (gradient_average <= Q_ONE))
    else $error("gradient average outside +-1.0");

  // gradient frames hold only the drain, which fits the cap width
  a_grad_frame_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && gradient_updated |-> (hold_ticks >> DRAIN_W) == '0)
    else $error("gradient frame carried jitter");

endmodule

bind adaptive_frame_hold_controller afhc_checker #(.TIME_WIDTH(TIME_WIDTH)) u_afhc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (frame_in.valid),
  .in_ready         (frame_in.ready),
  .out_valid        (hold_out.valid),
  .out_ready        (hold_out.ready),
  .hold_ticks       (hold_out.hold_ticks),
  .gradient_average (hold_out.gradient_average),
  .gradient_updated (hold_out.gradient_updated)
);

FILE: sim/afhc_hold_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the frame hold controller: predicts one hold beat per frame beat and
// compares it with what leaves hold_out. Depends on afhc_pkg and the afhc_ifs channels.

module afhc_hold_checker
  import afhc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  afhc_frame_if frame_mon,
  afhc_hold_if  hold_mon,
  afhc_cfg_if   cfg_mon,
  output int    fail_count,
  output int    pending
);

  localparam int TW = 48;

  typedef logic [TW-1:0] tick_t;

  typedef struct packed {
    tick_t  hold;
    drain_t drain;
    grad_t  avg;
    logic   upd;
  } hold_beat_t;

  drain_t     hold_cap;
  logic       started;
  tick_t      last_release;
  tick_t      prev_frame_time;
  tick_t      prev_jitter;
  grad_t      avg_grad;
  drain_t     drain_amt;
  hold_beat_t expected_holds[$];
  int         fails = 0;

  task automatic clear_controller();
    started         = 1'b0;
    last_release    = '0;
    prev_frame_time = '0;
    prev_jitter     = '0;
    avg_grad        = Q_HALF;
    drain_amt       = '0;
  endtask

  task automatic predict_hold(input logic en, input tick_t now, output hold_beat_t res);
    tick_t                ft;
    tick_t                jitter;
    tick_t                hold;
    tick_t                dmag;
    logic                 slower;
    logic                 grow;
    longint unsigned      max_drain;
    longint unsigned      quo;
    longint unsigned      mag;
    longint unsigned      step;
    longint unsigned      pj;
    longint signed        g;
    longint signed        acc;
    longint signed        avg_next;
    logic                 upd;
    hold = '0;
    upd  = 1'b0;
    if (!en) begin
      clear_controller();
    end else if (!started) begin
      last_release = now;
      started      = 1'b1;
    end else begin
      ft = now - last_release;
      // zero or wrapped-negative frame time: just resync the release point
      if (ft == '0 || ft[TW-1]) begin
        last_release = now;
      end else begin
        max_drain = {16'b0, ft} >> 1;
        if (max_drain > hold_cap) max_drain = hold_cap;
        if (drain_amt > max_drain) drain_amt = drain_t'(max_drain);
        jitter = (prev_jitter == '0) ? ft / tick_t'(JITTER_DIV) : '0;
        hold   = jitter + tick_t'(drain_amt);
        if (prev_jitter != '0) begin
          if (ft >= prev_frame_time) begin
            dmag   = ft - prev_frame_time;
            slower = 1'b1;
          end else begin
            dmag   = prev_frame_time - ft;
            slower = 1'b0;
          end
          pj = {16'b0, prev_jitter};
          if (dmag >= prev_jitter) begin
            g = longint'(Q_ONE);
          end else begin
            quo = ({16'b0, dmag} << FRAC_BITS) / pj;
            g   = longint'(quo);
          end
          if (slower) g = -g;
          acc      = longint'(EWMA_ALPHA) * g + longint'(EWMA_KEEP) * longint'(avg_grad);
          avg_next = (acc + longint'(Q_HALF)) >>> 16;
          avg_grad = grad_t'(avg_next);
          if (avg_next <= longint'(Q_HALF)) begin
            mag  = longint'(Q_HALF) - avg_next;
            grow = 1'b1;
          end else begin
            mag  = avg_next - longint'(Q_HALF);
            grow = 1'b0;
          end
          // (0.5 - avg) * prev_jitter / 2, split to keep the product in range
          step = mag * (pj >> 17) + ((mag * (pj & 64'h1FFFF)) >> 17);
          if (grow) begin
            if (step >= max_drain - drain_amt) drain_amt = drain_t'(max_drain);
            else drain_amt = drain_amt + drain_t'(step);
          end else begin
            if (step >= drain_amt) drain_amt = '0;
            else drain_amt = drain_amt - drain_t'(step);
          end
          upd = 1'b1;
        end
        prev_frame_time = ft;
        prev_jitter     = jitter;
        last_release    = now + hold;
      end
    end
    res = '{hold, drain_amt, avg_grad, upd};
  endtask

  always @(posedge clk) begin : track
    hold_beat_t want;
    hold_beat_t got;
    if (rst) begin
      hold_cap = HOLD_CAP_RESET;
      clear_controller();
      expected_holds.delete();
    end else begin
      if (hold_mon.valid && hold_mon.ready) begin
        got = '{hold_mon.hold_ticks, hold_mon.drain_ticks, hold_mon.gradient_average,
                hold_mon.gradient_updated};
        if (expected_holds.size() == 0) begin
          fails++;
          $display("%0t: unexpected hold beat, expected none, got hold %0d drain %0d avg %0d",
                   $time, got.hold, got.drain, got.avg);
        end else begin
          want = expected_holds.pop_front();
          if (got.hold !== want.hold) begin
            fails++;
            $display("%0t: hold_ticks expected %0d, got %0d", $time, want.hold, got.hold);
          end
          if (got.drain !== want.drain) begin
            fails++;
            $display("%0t: drain_ticks expected %0d, got %0d", $time, want.drain, got.drain);
          end
          if (got.avg !== want.avg) begin
            fails++;
            $display("%0t: gradient_average expected %0d, got %0d", $time, want.avg, got.avg);
          end
          if (got.upd !== want.upd) begin
            fails++;
            $display("%0t: gradient_updated expected %0b, got %0b", $time, want.upd, got.upd);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) hold_cap = cfg_mon.hold_cap_ticks;
      if (frame_mon.valid && frame_mon.ready) begin
        predict_hold(frame_mon.enable, frame_mon.arrive_time, want);
        expected_holds.push_back(want);
      end
    end
    fail_count <= fails;
    pending    <= expected_holds.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Top of the frame hold controller bench: clock, reset, frame and hold cap stimulus, verdict.
// Depends on afhc_pkg, afhc_ifs, the controller RTL and afhc_hold_checker.

module tb;
  import afhc_pkg::*;

  localparam int TW              = 48;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 64;
  localparam int PRESSURE_CYCLES = 300;
  localparam int PRESSURE_AFTER  = 140;
  localparam int ITEMS_PER_PHASE = 76;
  localparam int NUM_PHASES      = 5;
  localparam int NUM_DIRECTED    = 19;

  typedef logic [TW-1:0] tick_t;

  typedef enum int {
    PER_TINY, PER_MID, PER_FRAME, PER_HUGE, PER_RAMP_UP, PER_RAMP_DOWN
  } period_kind_e;

  typedef enum int {
    NOISE_DISABLE, NOISE_RANDOM, NOISE_REPEAT, NOISE_BACK
  } noise_kind_e;

  // disable, first event, zero frame time, +/-1 gradients, backwards time, wrap,
  // 2^47 frame time, largest positive frame time, frames too short for jitter
  localparam tick_t DIRECTED_TIMES [NUM_DIRECTED] = '{
    48'h0, 48'h0, 48'h0, 48'd1000, 48'd2000, 48'd3000, 48'd6000, 48'd7000, 48'd8005,
    48'd500, 48'hFFFF_FFFF_FFFF, 48'h100, 48'h8000_0000_0100, 48'hFF, 48'd285, 48'd325,
    48'hFFFF_FFFF_FFFF, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA
  };
  localparam bit [NUM_DIRECTED-1:0] DIRECTED_EN = 19'b1101111111111111110;

  logic  clk;
  logic  rst;
  logic  quiet;
  logic  idle_on;
  tick_t t_now;
  int    sent;
  int    fail_count;
  int    pending;

  afhc_frame_if #(.TIME_WIDTH(TW)) frame_ch ();
  afhc_hold_if  #(.TIME_WIDTH(TW)) hold_ch ();
  afhc_cfg_if                      cfg_ch ();

  adaptive_frame_hold_controller #(.TIME_WIDTH(TW)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .frame_in (frame_ch),
    .hold_out (hold_ch),
    .cfg      (cfg_ch)
  );

  afhc_hold_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .frame_mon  (frame_ch),
    .hold_mon   (hold_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic tick_t random_tick();
    return tick_t'({$urandom, $urandom});
  endfunction

  // valid stays up across back-to-back beats; it only drops for a gap
  task automatic send_frame(input logic en, input tick_t t);
    frame_ch.valid       <= 1'b1;
    frame_ch.enable      <= en;
    frame_ch.arrive_time <= t;
    do @(posedge clk); while (!frame_ch.ready);
    sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      frame_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_hold_cap(input drain_t cap);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.hold_cap_ticks <= cap;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_noise();
    case (noise_kind_e'($urandom_range(0, 3)))
      NOISE_DISABLE: begin
        t_now = random_tick();
        send_frame(1'b0, t_now);
      end
      NOISE_RANDOM: begin
        t_now = random_tick();
        send_frame(1'b1, t_now);
      end
      NOISE_REPEAT: send_frame(1'b1, t_now);
      default: begin
        t_now = t_now - tick_t'($urandom_range(1, 100000));
        send_frame(1'b1, t_now);
      end
    endcase
  endtask

  // a run of frames at a steady or ramping period with a little spread
  task automatic run_frame_train();
    period_kind_e    kind;
    longint unsigned per;
    longint unsigned d;
    int              len;
    kind    = period_kind_e'($urandom_range(0, 5));
    len     = $urandom_range(8, 40);
    idle_on = !quiet && ($urandom_range(0, 3) != 0);
    case (kind)
      PER_TINY:  per = $urandom_range(20, 150);
      PER_MID:   per = $urandom_range(1000, 400000);
      PER_FRAME: per = 166667;
      PER_HUGE:  per = longint'($urandom) << $urandom_range(4, 14);
      default:   per = $urandom_range(20000, 3000000);
    endcase
    if ($urandom_range(0, 2) == 0) send_frame(1'b0, t_now);
    repeat (len) begin
      if ($urandom_range(0, 15) == 0) begin
        send_noise();
      end else begin
        d = per - (per >> 5) + (((per >> 4) * $urandom_range(0, 256)) >> 8);
        t_now = t_now + tick_t'(d);
        send_frame(1'b1, t_now);
        if (kind == PER_RAMP_UP) per = per + (per >> 4);
        else if (kind == PER_RAMP_DOWN && per > 2000) per = per - (per >> 4);
      end
    end
  endtask

  task automatic wait_results_done();
    frame_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // hold_out: random stall bursts, one long hold-off to back up the input
  initial begin : hold_sink
    int   results_seen;
    logic pressed;
    results_seen = 0;
    pressed      = 1'b0;
    hold_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_ch.valid && hold_ch.ready) results_seen++;
      if (!pressed && results_seen >= PRESSURE_AFTER) begin
        pressed = 1'b1;
        hold_ch.ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        hold_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        hold_ch.ready <= 1'b1;
      end else begin
        hold_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((frame_ch.valid && frame_ch.ready) || (hold_ch.valid && hold_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int     ph;
    int     i;
    int     phase_start;
    drain_t cap;
    rst     <= 1'b1;
    quiet   = 1'b0;
    idle_on = 1'b0;
    sent    = 0;
    t_now   = '0;
    frame_ch.valid       <= 1'b0;
    frame_ch.enable      <= 1'b0;
    frame_ch.arrive_time <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.hold_cap_ticks <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      quiet = (ph == NUM_PHASES - 1);
      case (ph)
        0:       cap = HOLD_CAP_RESET;
        1:       cap = '0;
        2:       cap = '1;
        3:       cap = drain_t'($urandom_range(1, 200000));
        default: cap = drain_t'($urandom);
      endcase
      write_hold_cap(cap);
      if (ph == 0) begin
        idle_on = 1'b1;
        for (i = 0; i < NUM_DIRECTED; i++) begin
          t_now = DIRECTED_TIMES[i];
          send_frame(DIRECTED_EN[i], t_now);
        end
      end
      phase_start = sent;
      while (sent - phase_start < ITEMS_PER_PHASE) run_frame_train();
      wait_results_done();
    end
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
